/* design/bptc_pkg.sv */
package bptc_pkg;

  // Sequencer states of the compensation engine.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TMUL,
    ST_TFIN,
    ST_OMUL,
    ST_SMUL,
    ST_SENS,
    ST_LMUL,
    ST_HMUL,
    ST_ACC,
    ST_SUB,
    ST_PFIN,
    ST_OUT
  } state_e;

  // Configuration register indexes.
  localparam logic [7:0] REG_SENS       = 8'd0;
  localparam logic [7:0] REG_OFFSET     = 8'd1;
  localparam logic [7:0] REG_SENS_TC    = 8'd2;
  localparam logic [7:0] REG_OFFSET_TC  = 8'd3;
  localparam logic [7:0] REG_REF_TEMP   = 8'd4;
  localparam logic [7:0] REG_TEMP_SENS  = 8'd5;

  // Sample kinds.
  localparam logic KIND_TEMP = 1'b0;
  localparam logic KIND_PRES = 1'b1;

  // Field widths.
  localparam int COEF_W = 16;
  localparam int RAW_W  = 24;
  localparam int DT_W   = 25;
  localparam int TEMP_W = 18;
  localparam int PRES_W = 23;

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Intermediate widths.
  localparam int OFF_W  = 35;
  localparam int SENS_W = 34;
  localparam int ACC_W  = 60;

  // Constants of the compensation formulas.
  localparam int TEMP_BIAS = 64000;
  localparam int TEMP_MIN  = -131072;
  localparam int TEMP_MAX  = 131071;
  localparam int PRES_MIN  = -4194304;
  localparam int PRES_MAX  = 4194303;

endpackage

/* design/baro_pressure_temp_compensation_top.sv */
// Barometer first-order compensation engine.
// Input channel: in_valid_i / in_stall_o carry one item, a sample kind
// (0 = temperature conversion, 1 = pressure conversion) and a 24-bit raw value.
// Output channel: out_valid_o / out_stall_i carry one result per item: the last
// published pressure and temperature plus fresh and ignored flags.
// Coefficients C1..C6 are written through cfg_valid_i / cfg_ready_o with a
// register index and 16-bit data; the port is always ready.
// Each item runs through a small sequencer around one shared 25x18 signed
// multiplier. A temperature item passes ST_TMUL and ST_TFIN; a pressure item
// passes ST_OMUL, ST_SMUL, ST_SENS, ST_LMUL, ST_HMUL, ST_ACC, ST_SUB, ST_PFIN;
// a pressure item with no pending temperature goes straight to ST_OUT. The
// next item is accepted once the previous result has been moved into the
// output register, so one item is in work at a time; the multiplier steps of
// the pressure formula make its path the longest.
// When the receiver stalls, the result waits in the output register and the
// engine holds its finished result until that register frees up.
// Reset clears the coefficients, the calibration state and the output valid.
module baro_pressure_temp_compensation_top
  import bptc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     sample_kind_i,
  input  logic [RAW_W-1:0]         raw_value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [PRES_W-1:0] pressure_pa_o,
  output logic signed [TEMP_W-1:0] temperature_centi_o,
  output logic                     fresh_o,
  output logic                     ignored_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [7:0]               cfg_index_i,
  input  logic [COEF_W-1:0]        cfg_data_i
);

  state_e state_q, state_d;

  // Coefficient registers.
  logic [COEF_W-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;

  // Calibration state.
  logic signed [DT_W-1:0]   delta_temp_q;
  logic signed [TEMP_W-1:0] pending_temp_q, pending_temp_d;
  logic                     temp_pending_q;
  logic signed [PRES_W-1:0] pub_pres_q, pub_pres_d;
  logic signed [TEMP_W-1:0] pub_temp_q;

  // Working registers.
  logic [RAW_W-1:0]         raw_q;
  logic                     fresh_q, ignored_q;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [OFF_W-1:0]  off_q, off_d;
  logic signed [SENS_W-1:0] sens_q, sens_d;
  logic signed [ACC_W-1:0]  acc_q, acc_full_d, acc_diff_d;

  // Output register.
  logic                     out_valid_q;
  logic signed [PRES_W-1:0] out_pres_q;
  logic signed [TEMP_W-1:0] out_temp_q;
  logic                     out_fresh_q, out_ignored_q;

  // Control.
  logic                      in_accept;
  logic                      out_free;
  logic                      out_load;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;

  // Temperature finishing arithmetic.
  logic signed [25:0] t_sum, t_adj, t_div;
  // Pressure finishing arithmetic.
  logic signed [29:0] p_y, p_adj, p_div;

  assign cfg_ready_o = 1'b1;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (sample_kind_i == KIND_TEMP) begin
            state_d = ST_TMUL;
          end else if (temp_pending_q) begin
            state_d = ST_OMUL;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_TMUL: state_d = ST_TFIN;
      ST_TFIN: state_d = ST_OUT;
      ST_OMUL: state_d = ST_SMUL;
      ST_SMUL: state_d = ST_SENS;
      ST_SENS: state_d = ST_LMUL;
      ST_LMUL: state_d = ST_HMUL;
      ST_HMUL: state_d = ST_ACC;
      ST_ACC:  state_d = ST_SUB;
      ST_SUB:  state_d = ST_PFIN;
      ST_PFIN: state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output logic of the sequencer: handshake and multiplier operand select.
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    out_load   = (state_q == ST_OUT) && out_free;
    mul_a      = delta_temp_q;
    mul_b      = {2'b00, c6_q};
    case (state_q)
      ST_TMUL: begin
        mul_a = delta_temp_q;
        mul_b = {2'b00, c6_q};
      end
      ST_OMUL: begin
        mul_a = delta_temp_q;
        mul_b = {2'b00, c4_q};
      end
      ST_SMUL: begin
        mul_a = delta_temp_q;
        mul_b = {2'b00, c3_q};
      end
      ST_LMUL: begin
        mul_a = {1'b0, raw_q};
        mul_b = {1'b0, sens_q[16:0]};
      end
      ST_HMUL: begin
        mul_a = {1'b0, raw_q};
        mul_b = {sens_q[SENS_W-1], sens_q[SENS_W-1:17]};
      end
      default: begin
        mul_a = delta_temp_q;
        mul_b = {2'b00, c6_q};
      end
    endcase
  end

  // Shared multiplier, registered every cycle.
  assign prod_d = mul_a * mul_b;

  // OFF and SENS from the products with dT.
  assign off_d  = $signed({3'b000, c2_q, 16'h0000}) + OFF_W'(prod_q >>> 7);
  assign sens_d = $signed({3'b000, c1_q, 15'h0000}) + SENS_W'(prod_q >>> 8);

  // Wide product of raw and SENS from its high and low partial products, then scaled down and OFF subtracted.
  assign acc_full_d = (ACC_W'(prod_q) <<< 17) + acc_q;
  assign acc_diff_d = ACC_W'(acc_q >>> 21) - ACC_W'(off_q);

  // Temperature: bias, divide by 32 toward zero, saturate.
  always_comb begin
    t_sum = 26'(prod_q >>> 18) + 26'(TEMP_BIAS);
    t_adj = t_sum + (t_sum[25] ? 26'sd31 : 26'sd0);
    t_div = t_adj >>> 5;
    if (t_div < 26'(TEMP_MIN)) begin
      pending_temp_d = TEMP_W'(TEMP_MIN);
    end else if (t_div > 26'(TEMP_MAX)) begin
      pending_temp_d = TEMP_W'(TEMP_MAX);
    end else begin
      pending_temp_d = TEMP_W'(t_div);
    end
  end

  // Pressure: drop ten bits, divide by 32 toward zero, saturate.
  always_comb begin
    p_y   = 30'(acc_q >>> 10);
    p_adj = p_y + (p_y[29] ? 30'sd31 : 30'sd0);
    p_div = p_adj >>> 5;
    if (p_div < 30'(PRES_MIN)) begin
      pub_pres_d = PRES_W'(PRES_MIN);
    end else if (p_div > 30'(PRES_MAX)) begin
      pub_pres_d = PRES_W'(PRES_MAX);
    end else begin
      pub_pres_d = PRES_W'(p_div);
    end
  end

  // Sequencer state, coefficients, calibration state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      c1_q           <= '0;
      c2_q           <= '0;
      c3_q           <= '0;
      c4_q           <= '0;
      c5_q           <= '0;
      c6_q           <= '0;
      delta_temp_q   <= '0;
      pending_temp_q <= '0;
      temp_pending_q <= 1'b0;
      pub_pres_q     <= '0;
      pub_temp_q     <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_SENS:      c1_q <= cfg_data_i;
          REG_OFFSET:    c2_q <= cfg_data_i;
          REG_SENS_TC:   c3_q <= cfg_data_i;
          REG_OFFSET_TC: c4_q <= cfg_data_i;
          REG_REF_TEMP:  c5_q <= cfg_data_i;
          REG_TEMP_SENS: c6_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_accept && sample_kind_i == KIND_TEMP) begin
        delta_temp_q <= $signed({1'b0, raw_value_i}) - $signed({1'b0, c5_q, 8'h00});
      end
      if (state_q == ST_TFIN) begin
        pending_temp_q <= pending_temp_d;
        temp_pending_q <= 1'b1;
      end
      if (state_q == ST_PFIN) begin
        pub_pres_q     <= pub_pres_d;
        pub_temp_q     <= pending_temp_q;
        temp_pending_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working and output payload registers.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (in_accept) begin
      raw_q     <= raw_value_i;
      fresh_q   <= (sample_kind_i == KIND_PRES) && temp_pending_q;
      ignored_q <= (sample_kind_i == KIND_PRES) && !temp_pending_q;
    end
    if (state_q == ST_SMUL) begin
      off_q <= off_d;
    end
    if (state_q == ST_SENS) begin
      sens_q <= sens_d;
    end
    if (state_q == ST_HMUL) begin
      acc_q <= ACC_W'(prod_q);
    end else if (state_q == ST_ACC) begin
      acc_q <= acc_full_d;
    end else if (state_q == ST_SUB) begin
      acc_q <= acc_diff_d;
    end
    if (out_load) begin
      out_pres_q    <= pub_pres_q;
      out_temp_q    <= pub_temp_q;
      out_fresh_q   <= fresh_q;
      out_ignored_q <= ignored_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign pressure_pa_o       = out_pres_q;
  assign temperature_centi_o = out_temp_q;
  assign fresh_o             = out_fresh_q;
  assign ignored_o           = out_ignored_q;

endmodule
